// ----- sv/stack_machine_executor_defines.svh -----
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH
`ifndef SYNTH
`define SME_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define SME_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SME_ASSERT(label, clk, rst_n, prop)
`define SME_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- sv/sme_pkg.sv -----
// ----------------------------------------------------------------------------
// Stack machine executor package
// Operation codes, status codes, output kinds and control state.
// ----------------------------------------------------------------------------
package sme_pkg;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_DUP = 5'd1, OP_COPY = 5'd2, OP_SWAP = 5'd3,
    OP_DISCARD = 5'd4, OP_SLIDE = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7,
    OP_MUL = 5'd8, OP_DIV = 5'd9, OP_MOD = 5'd10, OP_STORE = 5'd11,
    OP_RETRIEVE = 5'd12, OP_OUTCHAR = 5'd13, OP_OUTNUM = 5'd14,
    OP_INCHAR = 5'd15, OP_INNUM = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZERO = 3'd3,
    ST_HEAPBAD = 3'd4, ST_BADOP = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0, KIND_CHAR = 2'd1, KIND_NUM = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_HEAPRD, S_SWAP2
  } state_e;

  localparam logic [31:0] CharZero = 32'd48;

endpackage

// ----- sv/sme_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sme_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/sme_div.sv -----
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sme_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic [31:0] q_q, q_d;
  logic [32:0] r_q, r_d;
  logic [31:0] d_q, d_d;
  logic        nq_q, nq_d, nr_q, nr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [32:0] trial;
  logic [31:0] abs_a, abs_b;

  assign abs_a = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign abs_b = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign trial = {r_q[31:0], q_q[31]} - {1'b0, d_q};

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; nq_d = nq_q; nr_d = nr_q;
    cnt_d = cnt_q; run_d = run_q;
    if (start_i) begin
      q_d = abs_a; r_d = '0; d_d = abs_b;
      nq_d = a_i[31] ^ b_i[31]; nr_d = a_i[31];
      cnt_d = 6'd0; run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[32]) begin
        r_d = trial;
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[31:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; nq_q <= nq_d; nr_q <= nr_d;
  end

  assign done_o = !run_q && cnt_q == 6'd32;
  assign quo_o  = nq_q ? (~q_q + 32'd1) : q_q;
  assign rem_o  = nr_q ? (~r_q[31:0] + 32'd1) : r_q[31:0];

endmodule

// ----- sv/stack_machine_executor.sv -----
// ----------------------------------------------------------------------------
// Stack machine executor
// Runs one stack instruction per word on a memory stack and a memory heap.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// command  in         start, busy         op_i, argument_i
// result   out        strobe              out_kind_o, out_data_o, status_o
//
// Most instructions pass through S_READ and S_EXEC, and strobe is registered
// from S_EXEC; swap and retrieve that succeed add S_SWAP2 or S_HEAPRD, and
// div and mod wait in S_DIV for the one-bit-per-cycle divider. After reset
// the heap is cleared one entry per cycle, with busy high. The result cannot be stalled.
module stack_machine_executor #(
  parameter int STACK_DEPTH = 256,
  parameter int HEAP_DEPTH  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  op_i,
  input  logic signed [31:0] argument_i,
  output logic        strobe,
  output logic [1:0]  out_kind_o,
  output logic signed [31:0] out_data_o,
  output logic [2:0]  status_o
);

  `include "stack_machine_executor_defines.svh"

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int LW  = SAW + 1;

  sme_pkg::state_e state_q, state_d;
  logic [LW-1:0]  lvl_q, lvl_d;
  logic [4:0]     op_q;
  logic [31:0]    arg_q;
  logic [HAW:0]   clr_q, clr_d;
  logic [31:0]    top_q, sec_q;
  logic [SAW-1:0] ra, wa;
  logic           swe, hwe;
  logic [31:0]    swd, srd, hwd, hrd;
  logic [HAW-1:0] hra, hwa;
  logic           div_start, div_done;
  logic [31:0]    quo, rem;
  logic           res_v;
  logic [1:0]     res_k;
  logic [31:0]    res_d;
  logic [2:0]     res_s;
  logic           cp_ok, haddr_ok, a_haddr_ok;
  logic [31:0]    top_now;

  sme_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(swe), .waddr_i(wa), .wdata_i(swd), .raddr_i(ra), .rdata_o(srd));
  sme_ram #(.Width(32), .Depth(HEAP_DEPTH)) u_heap (
    .clk_i, .we_i(hwe), .waddr_i(hwa), .wdata_i(hwd), .raddr_i(hra), .rdata_o(hrd));
  sme_div u_div (.clk_i, .rst_ni, .start_i(div_start), .a_i(sec_q), .b_i(top_now),
    .done_o(div_done), .quo_o(quo), .rem_o(rem));

  assign busy = state_q != sme_pkg::S_IDLE;
  assign cp_ok = !arg_q[31] && arg_q != 32'd0 && arg_q <= {{(32-LW){1'b0}}, lvl_q};
  assign top_now = (state_q == sme_pkg::S_EXEC) ? srd : top_q;
  assign haddr_ok = !top_now[31] && top_now < HEAP_DEPTH;
  assign a_haddr_ok = !sec_q[31] && sec_q < HEAP_DEPTH;

  always_comb begin
    ra = lvl_q[SAW-1:0] - SAW'(1);
    if (state_q == sme_pkg::S_IDLE && start) begin
      ra = lvl_q[SAW-1:0] - SAW'(2);
      if (op_i == sme_pkg::OP_COPY) ra = lvl_q[SAW-1:0] - argument_i[SAW-1:0];
    end else if (state_q == sme_pkg::S_READ) begin
      ra = lvl_q[SAW-1:0] - SAW'(1);
    end
  end

  always_comb begin
    state_d = state_q; lvl_d = lvl_q; clr_d = clr_q;
    swe = 1'b0; wa = lvl_q[SAW-1:0]; swd = srd;
    hwe = 1'b0; hwa = top_now[HAW-1:0]; hwd = '0; hra = top_now[HAW-1:0];
    div_start = 1'b0;
    res_v = 1'b0; res_k = sme_pkg::KIND_NONE; res_d = '0; res_s = sme_pkg::ST_OK;
    case (state_q)
      sme_pkg::S_CLEAR: begin
        hwe = 1'b1; hwa = clr_q[HAW-1:0]; hwd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (HAW+1)'(HEAP_DEPTH - 1)) state_d = sme_pkg::S_IDLE;
      end
      sme_pkg::S_IDLE: if (start) state_d = sme_pkg::S_READ;
      sme_pkg::S_READ: state_d = sme_pkg::S_EXEC;
      sme_pkg::S_EXEC: begin
        res_v = 1'b1; state_d = sme_pkg::S_IDLE;
        case (op_q)
          sme_pkg::OP_PUSH, sme_pkg::OP_DUP, sme_pkg::OP_COPY: begin
            if (op_q == sme_pkg::OP_DUP && lvl_q == '0) res_s = sme_pkg::ST_UNDER;
            else if (lvl_q >= LW'(STACK_DEPTH)) res_s = sme_pkg::ST_OVER;
            else begin
              swe = 1'b1; lvl_d = lvl_q + 1'b1;
              if (op_q == sme_pkg::OP_PUSH) swd = arg_q;
              else if (op_q == sme_pkg::OP_DUP) swd = srd;
              else swd = cp_ok ? sec_q : 32'd0;
            end
          end
          sme_pkg::OP_SWAP: begin
            if (lvl_q < LW'(2)) res_s = sme_pkg::ST_UNDER;
            else begin
              res_v = 1'b0; swe = 1'b1; wa = lvl_q[SAW-1:0] - SAW'(1); swd = sec_q;
              state_d = sme_pkg::S_SWAP2;
            end
          end
          sme_pkg::OP_DISCARD: begin
            if (lvl_q == '0) res_s = sme_pkg::ST_UNDER;
            else lvl_d = lvl_q - 1'b1;
          end
          sme_pkg::OP_SLIDE: begin
            if (lvl_q == '0) res_s = sme_pkg::ST_UNDER;
            else if (!arg_q[31] && arg_q != 32'd0) begin
              if (arg_q > {{(32-LW){1'b0}}, lvl_q - 1'b1}) res_s = sme_pkg::ST_UNDER;
              else begin
                swe = 1'b1; wa = lvl_q[SAW-1:0] - SAW'(1) - arg_q[SAW-1:0]; swd = srd;
                lvl_d = lvl_q - arg_q[LW-1:0];
              end
            end
          end
          sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
          sme_pkg::OP_MOD: begin
            if (lvl_q < LW'(2)) res_s = sme_pkg::ST_UNDER;
            else if ((op_q == sme_pkg::OP_DIV || op_q == sme_pkg::OP_MOD) && srd == '0)
              res_s = sme_pkg::ST_DIVZERO;
            else if (op_q == sme_pkg::OP_DIV || op_q == sme_pkg::OP_MOD) begin
              res_v = 1'b0; div_start = 1'b1; state_d = sme_pkg::S_DIV;
            end else begin
              swe = 1'b1; wa = lvl_q[SAW-1:0] - SAW'(2); lvl_d = lvl_q - 1'b1;
              if (op_q == sme_pkg::OP_ADD) swd = sec_q + srd;
              else if (op_q == sme_pkg::OP_SUB) swd = sec_q - srd;
              else swd = sec_q * srd;
            end
          end
          sme_pkg::OP_STORE: begin
            if (lvl_q < LW'(2)) res_s = sme_pkg::ST_UNDER;
            else if (!a_haddr_ok) res_s = sme_pkg::ST_HEAPBAD;
            else begin
              hwe = 1'b1; hwa = sec_q[HAW-1:0]; hwd = srd; lvl_d = lvl_q - LW'(2);
            end
          end
          sme_pkg::OP_RETRIEVE: begin
            if (lvl_q == '0) res_s = sme_pkg::ST_UNDER;
            else if (!haddr_ok) res_s = sme_pkg::ST_HEAPBAD;
            else begin
              res_v = 1'b0; state_d = sme_pkg::S_HEAPRD;
            end
          end
          sme_pkg::OP_OUTCHAR, sme_pkg::OP_OUTNUM: begin
            if (lvl_q == '0) res_s = sme_pkg::ST_UNDER;
            else begin
              lvl_d = lvl_q - 1'b1;
              if (op_q == sme_pkg::OP_OUTCHAR) begin
                res_k = sme_pkg::KIND_CHAR; res_d = {24'd0, srd[7:0] + sme_pkg::CharZero[7:0]};
              end else begin
                res_k = sme_pkg::KIND_NUM; res_d = srd;
              end
            end
          end
          sme_pkg::OP_INCHAR, sme_pkg::OP_INNUM: begin
            if (lvl_q == '0) res_s = sme_pkg::ST_UNDER;
            else if (!haddr_ok) res_s = sme_pkg::ST_HEAPBAD;
            else begin
              hwe = 1'b1; lvl_d = lvl_q - 1'b1;
              hwd = (op_q == sme_pkg::OP_INCHAR) ? ({24'd0, arg_q[7:0]} - sme_pkg::CharZero)
                                                 : arg_q;
            end
          end
          default: res_s = sme_pkg::ST_BADOP;
        endcase
      end
      sme_pkg::S_DIV: begin
        if (div_done) begin
          res_v = 1'b1; state_d = sme_pkg::S_IDLE;
          swe = 1'b1; wa = lvl_q[SAW-1:0] - SAW'(2); lvl_d = lvl_q - 1'b1;
          swd = (op_q == sme_pkg::OP_DIV) ? quo : rem;
        end
      end
      sme_pkg::S_HEAPRD: begin
        res_v = 1'b1; state_d = sme_pkg::S_IDLE;
        swe = 1'b1; wa = lvl_q[SAW-1:0] - SAW'(1); swd = hrd;
      end
      sme_pkg::S_SWAP2: begin
        res_v = 1'b1; state_d = sme_pkg::S_IDLE;
        swe = 1'b1; wa = lvl_q[SAW-1:0] - SAW'(2); swd = top_q;
      end
      default: state_d = sme_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sme_pkg::S_CLEAR;
      lvl_q <= '0;
      clr_q <= '0;
      strobe <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q <= lvl_d;
      clr_q <= clr_d;
      strobe <= res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sme_pkg::S_IDLE && start) begin
      op_q <= op_i;
      arg_q <= argument_i;
    end
    if (state_q == sme_pkg::S_READ) sec_q <= srd;
    if (state_q == sme_pkg::S_EXEC) top_q <= srd;
    out_kind_o <= res_k;
    out_data_o <= res_d;
    status_o <= res_s;
  end

  `SME_ASSERT(a_lvl_range, clk_i, rst_ni, lvl_q <= LW'(STACK_DEPTH))
  `SME_ASSERT(a_strobe_busy, clk_i, rst_ni, strobe |-> $past(busy))
  `SME_ASSERT(a_div_only, clk_i, rst_ni,
    state_q == sme_pkg::S_DIV |-> (op_q == sme_pkg::OP_DIV || op_q == sme_pkg::OP_MOD))
  `SME_ASSERT(a_lvl_step, clk_i, rst_ni,
    state_q == sme_pkg::S_IDLE |=> $stable(lvl_q))

endmodule
